// ===== rtl/hjvr_pkg.sv =====
package hjvr_pkg;

    localparam int AXES        = 3;
    localparam int SHAPE_DEPTH = 256;

    localparam int REPORT_AXES = 3;
    localparam int REP_N       = (AXES < REPORT_AXES) ? AXES : REPORT_AXES;
    localparam int AXIS_IW     = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int AXIS_CW     = $clog2(AXES + 1);
    localparam int ROM_IW      = $clog2(SHAPE_DEPTH + 1);
    localparam int SHAPE_W     = 17;
    localparam int FRAC_W      = 17;
    localparam int FRAC_ONE    = 65536;
    localparam int RANGE_COUNT = 5;

    localparam logic [31:0] DIV20_MAGIC = 32'hCCCC_CCCD;
    localparam logic [31:0] DECAY_BIAS  = 32'd19;

    localparam logic [2:0] CFG_AXIS_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_SPEED_RANGE    = 3'd1;
    localparam logic [2:0] CFG_RATIO_GAIN     = 3'd2;
    localparam logic [2:0] CFG_MAX_SPEED      = 3'd3;
    localparam logic [2:0] CFG_MAX_SPEED_STEP = 3'd4;
    localparam logic [2:0] CFG_TICK_PERIOD    = 3'd5;

    localparam logic [2:0] RANGE_FINEST = 3'd0;
    localparam logic [2:0] RANGE_FINE   = 3'd1;
    localparam logic [2:0] RANGE_MID    = 3'd2;
    localparam logic [2:0] RANGE_COARSE = 3'd3;
    localparam logic [2:0] RANGE_MAX    = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic [2:0]  axis_enable;
        logic [2:0]  speed_range;
        logic [23:0] ratio_gain;
        logic [23:0] max_speed;
        logic [23:0] max_speed_step;
        logic [16:0] tick_period;
    } cfg_t;

    typedef logic [SHAPE_DEPTH:0][SHAPE_W-1:0] shape_rom_t;

    function automatic logic [23:0] base_speed(input logic [2:0] speed_range);
        logic [23:0] speed;
        case (speed_range)
            RANGE_FINEST: speed = 24'd1000;
            RANGE_FINE:   speed = 24'd10000;
            RANGE_MID:    speed = 24'd100000;
            RANGE_COARSE: speed = 24'd1000000;
            RANGE_MAX:    speed = 24'd10000000;
            default:      speed = 24'd1000;
        endcase
        return speed;
    endfunction

    // entry i = largest Y with Y^10 * DEPTH^7 <= i^7 * 2^160, i.e. floor(65536 * x^0.7)
    function automatic shape_rom_t shape_build();
        shape_rom_t  rom;
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  mid;
        for (int i = 0; i <= SHAPE_DEPTH; i++) begin
            rhs = 256'd1;
            for (int k = 0; k < 7; k++) begin
                rhs = rhs * 256'(i);
            end
            rhs = rhs << 160;
            lo = 17'd0;
            hi = 17'd65537;
            while ((hi - lo) > 17'd1) begin
                mid = lo + ((hi - lo) >> 1);
                lhs = 256'd1;
                for (int k = 0; k < 10; k++) begin
                    lhs = lhs * 256'(mid);
                end
                for (int k = 0; k < 7; k++) begin
                    lhs = lhs * 256'(SHAPE_DEPTH);
                end
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            rom[i] = lo;
        end
        return rom;
    endfunction

    localparam shape_rom_t SHAPE_ROM = shape_build();

endpackage

// ===== rtl/hjvr_mul.sv =====
module hjvr_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/hjvr_core.sv =====
module hjvr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  hjvr_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [15:0]         s_encoder_count,
    input  logic [1:0]          s_load_axis,
    input  logic signed [63:0]  s_start_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_position_x,
    output logic signed [63:0]  m_position_y,
    output logic signed [63:0]  m_position_z,
    output logic signed [31:0]  m_velocity_x,
    output logic signed [31:0]  m_velocity_y,
    output logic signed [31:0]  m_velocity_z,
    output logic signed [15:0]  m_count_delta
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FRAC,
        ST_INDEX,
        ST_INTERP,
        ST_TARGET,
        ST_SLEW,
        ST_INTEG_MUL,
        ST_INTEG,
        ST_DECAY_MUL,
        ST_DECAY_WB,
        ST_OUT
    } state_t;

    state_t                              state_reg;
    logic                                op_reg;
    logic [15:0]                         cnt_reg;
    logic [1:0]                          ax_reg;
    logic signed [63:0]                  start_reg;
    logic [15:0]                         prev_reg;
    logic [15:0]                         delta_reg;
    logic [hjvr_pkg::SHAPE_W-1:0]        lo_reg;
    logic signed [24:0]                  target_reg;
    logic [hjvr_pkg::AXIS_CW-1:0]        axis_reg;
    logic signed [31:0]                  vel_reg [hjvr_pkg::AXES];
    logic signed [63:0]                  pos_reg [hjvr_pkg::AXES];

    logic                                m_valid_reg;
    logic signed [63:0]                  m_pos_reg [hjvr_pkg::REPORT_AXES];
    logic signed [31:0]                  m_vel_reg [hjvr_pkg::REPORT_AXES];
    logic [15:0]                         m_delta_reg;

    logic [31:0]                         mul_a;
    logic [31:0]                         mul_b;
    logic [63:0]                         mul_prod;

    logic [hjvr_pkg::AXIS_IW-1:0]        aidx;
    logic                                last_axis;
    logic [hjvr_pkg::AXES+2:0]           mask_wide;
    logic [hjvr_pkg::AXES-1:0]           axis_en;
    logic signed [31:0]                  cur_vel;
    logic signed [63:0]                  cur_pos;
    logic [31:0]                         vel_mag;

    logic [15:0]                         raw_delta;
    logic [15:0]                         delta_mag;
    logic [hjvr_pkg::FRAC_W-1:0]         frac;
    logic [hjvr_pkg::ROM_IW-1:0]         shape_k;
    logic [hjvr_pkg::ROM_IW-1:0]         shape_kn;
    logic [15:0]                         shape_r;
    logic [hjvr_pkg::SHAPE_W-1:0]        shape_lo;
    logic [hjvr_pkg::SHAPE_W-1:0]        shape_diff;
    logic [hjvr_pkg::SHAPE_W-1:0]        shape_val;
    logic [41:0]                         tgt_round;
    logic [25:0]                         tgt_mag;
    logic [23:0]                         tgt_clip;
    logic signed [24:0]                  tgt_signed;

    logic signed [33:0]                  sl_vel;
    logic signed [33:0]                  sl_dv;
    logic signed [33:0]                  sl_step;
    logic signed [33:0]                  sl_dvc;
    logic signed [33:0]                  sl_sum;
    logic signed [31:0]                  vel_slew;

    logic [48:0]                         int_mag;
    logic signed [63:0]                  int_inc;
    logic signed [64:0]                  int_sum;
    logic signed [63:0]                  pos_sat;

    logic [27:0]                         dec_q;
    logic [31:0]                         dec_r;
    logic signed [31:0]                  vel_decay;

    logic signed [63:0]                  pos_rep [hjvr_pkg::REPORT_AXES];
    logic signed [31:0]                  vel_rep [hjvr_pkg::REPORT_AXES];

    hjvr_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    always_comb begin
        aidx      = axis_reg[hjvr_pkg::AXIS_IW-1:0];
        last_axis = (axis_reg == hjvr_pkg::AXIS_CW'(hjvr_pkg::AXES - 1));
        mask_wide = {{hjvr_pkg::AXES{1'b0}}, cfg.axis_enable};
        axis_en   = mask_wide[hjvr_pkg::AXES-1:0];
        cur_vel   = vel_reg[aidx];
        cur_pos   = pos_reg[aidx];
        vel_mag   = cur_vel[31] ? (~cur_vel + 32'd1) : cur_vel;

        raw_delta = cnt_reg - prev_reg;
        delta_mag = raw_delta[15] ? (~raw_delta + 16'd1) : raw_delta;

        frac = (mul_prod > 64'(hjvr_pkg::FRAC_ONE)) ?
               hjvr_pkg::FRAC_W'(hjvr_pkg::FRAC_ONE) : mul_prod[hjvr_pkg::FRAC_W-1:0];

        shape_k    = mul_prod[16 +: hjvr_pkg::ROM_IW];
        shape_r    = mul_prod[15:0];
        shape_kn   = (shape_k >= hjvr_pkg::ROM_IW'(hjvr_pkg::SHAPE_DEPTH)) ?
                     shape_k : shape_k + 1'b1;
        shape_lo   = hjvr_pkg::SHAPE_ROM[shape_k];
        shape_diff = hjvr_pkg::SHAPE_ROM[shape_kn] - shape_lo;
        shape_val  = lo_reg + mul_prod[32:16];

        tgt_round  = mul_prod[41:0] + 42'd32768;
        tgt_mag    = tgt_round[41:16];
        tgt_clip   = (tgt_mag > {2'b00, cfg.max_speed}) ? cfg.max_speed : tgt_mag[23:0];
        tgt_signed = delta_reg[15] ? -$signed({1'b0, tgt_clip}) : $signed({1'b0, tgt_clip});

        sl_vel  = 34'(cur_vel);
        sl_dv   = 34'(target_reg) - sl_vel;
        sl_step = $signed({10'b0, cfg.max_speed_step});
        if (sl_dv > sl_step) begin
            sl_dvc = sl_step;
        end else if (sl_dv < -sl_step) begin
            sl_dvc = -sl_step;
        end else begin
            sl_dvc = sl_dv;
        end
        sl_sum = sl_vel + sl_dvc;
        if (sl_sum > 34'sd2147483647) begin
            vel_slew = 32'sh7FFF_FFFF;
        end else if (sl_sum < -34'sd2147483648) begin
            vel_slew = 32'sh8000_0000;
        end else begin
            vel_slew = sl_sum[31:0];
        end

        int_mag = mul_prod[48:0];
        int_inc = cur_vel[31] ? -$signed({15'b0, int_mag}) : $signed({15'b0, int_mag});
        int_sum = 65'(cur_pos) + 65'(int_inc);
        if (int_sum[64] != int_sum[63]) begin
            pos_sat = int_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            pos_sat = int_sum[63:0];
        end

        // |v|*19/20 = |v| - ceil(|v|/20)
        dec_q     = mul_prod[63:36];
        dec_r     = vel_mag - {4'b0, dec_q};
        vel_decay = cur_vel[31] ? (~dec_r + 32'd1) : dec_r;

        for (int i = 0; i < hjvr_pkg::REPORT_AXES; i++) begin
            pos_rep[i] = '0;
            vel_rep[i] = '0;
        end
        for (int i = 0; i < hjvr_pkg::REP_N; i++) begin
            pos_rep[i] = pos_reg[i];
            vel_rep[i] = vel_reg[i];
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DISPATCH: begin
                mul_a = {16'b0, delta_mag};
                mul_b = {8'b0, cfg.ratio_gain};
            end
            ST_FRAC: begin
                mul_a = 32'(frac);
                mul_b = 32'(hjvr_pkg::SHAPE_DEPTH);
            end
            ST_INDEX: begin
                mul_a = 32'(shape_diff);
                mul_b = {16'b0, shape_r};
            end
            ST_INTERP: begin
                mul_a = 32'(shape_val);
                mul_b = {8'b0, hjvr_pkg::base_speed(cfg.speed_range)};
            end
            ST_INTEG_MUL: begin
                mul_a = vel_mag;
                mul_b = {15'b0, cfg.tick_period};
            end
            ST_DECAY_MUL: begin
                mul_a = vel_mag + hjvr_pkg::DECAY_BIAS;
                mul_b = hjvr_pkg::DIV20_MAGIC;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            prev_reg    <= '0;
            axis_reg    <= '0;
            for (int i = 0; i < hjvr_pkg::AXES; i++) begin
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end else begin
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_operation;
                        cnt_reg   <= s_encoder_count;
                        ax_reg    <= s_load_axis;
                        start_reg <= s_start_position;
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    axis_reg <= '0;
                    if (op_reg == hjvr_pkg::OP_LOAD) begin
                        prev_reg  <= cnt_reg;
                        delta_reg <= '0;
                        for (int i = 0; i < hjvr_pkg::AXES; i++) begin
                            vel_reg[i] <= '0;
                            if (32'(ax_reg) == i) begin
                                pos_reg[i] <= start_reg;
                            end
                        end
                        state_reg <= ST_OUT;
                    end else if (cfg.axis_enable == 3'd0) begin
                        delta_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        prev_reg  <= cnt_reg;
                        delta_reg <= raw_delta;
                        state_reg <= (raw_delta == 16'd0) ? ST_DECAY_MUL : ST_FRAC;
                    end
                end
                ST_FRAC: begin
                    state_reg <= ST_INDEX;
                end
                ST_INDEX: begin
                    lo_reg    <= shape_lo;
                    state_reg <= ST_INTERP;
                end
                ST_INTERP: begin
                    state_reg <= ST_TARGET;
                end
                ST_TARGET: begin
                    target_reg <= tgt_signed;
                    state_reg  <= ST_SLEW;
                end
                ST_SLEW: begin
                    if (axis_en[aidx]) begin
                        vel_reg[aidx] <= vel_slew;
                        state_reg     <= ST_INTEG_MUL;
                    end else if (last_axis) begin
                        state_reg <= ST_OUT;
                    end else begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_INTEG_MUL: begin
                    state_reg <= ST_INTEG;
                end
                ST_INTEG: begin
                    pos_reg[aidx] <= pos_sat;
                    if (last_axis) begin
                        state_reg <= ST_OUT;
                    end else begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_SLEW;
                    end
                end
                ST_DECAY_MUL: begin
                    state_reg <= ST_DECAY_WB;
                end
                ST_DECAY_WB: begin
                    vel_reg[aidx] <= vel_decay;
                    if (last_axis) begin
                        state_reg <= ST_OUT;
                    end else begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_DECAY_MUL;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int i = 0; i < hjvr_pkg::REPORT_AXES; i++) begin
                            m_pos_reg[i] <= pos_rep[i];
                            m_vel_reg[i] <= vel_rep[i];
                        end
                        m_delta_reg <= delta_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_position_x  = m_pos_reg[0];
    assign m_position_y  = m_pos_reg[1];
    assign m_position_z  = m_pos_reg[2];
    assign m_velocity_x  = m_vel_reg[0];
    assign m_velocity_y  = m_vel_reg[1];
    assign m_velocity_z  = m_vel_reg[2];
    assign m_count_delta = m_delta_reg;

endmodule

// ===== rtl/handwheel_jog_velocity_ramp.sv =====
// A load, or a tick with an empty mask, goes from dispatch straight to the output state; a
// standstill tick (decay) steps through every axis, a moving tick through each enabled axis.
// No new item is taken until the last result is registered for output; a held result stalls input.
// The single shared 32x32 multiplier is visited once per step and per axis.
// aresetn is synchronous, active low: config to defaults, count, velocities, positions to zero.
module handwheel_jog_velocity_ramp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_index,
    input  logic [23:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [15:0]        s_encoder_count,
    input  logic [1:0]         s_load_axis,
    input  logic signed [63:0] s_start_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_position_x,
    output logic signed [63:0] m_position_y,
    output logic signed [63:0] m_position_z,
    output logic signed [31:0] m_velocity_x,
    output logic signed [31:0] m_velocity_y,
    output logic signed [31:0] m_velocity_z,
    output logic signed [15:0] m_count_delta
);

    hjvr_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_enable    <= 3'd1;
            cfg_reg.speed_range    <= hjvr_pkg::RANGE_MID;
            cfg_reg.ratio_gain     <= 24'd327680;
            cfg_reg.max_speed      <= 24'd100000;
            cfg_reg.max_speed_step <= 24'd500;
            cfg_reg.tick_period    <= 17'd1000;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                hjvr_pkg::CFG_AXIS_ENABLE: begin
                    cfg_reg.axis_enable <= cfg_wr_data[2:0];
                end
                hjvr_pkg::CFG_SPEED_RANGE: begin
                    if (cfg_wr_data[2:0] < 3'(hjvr_pkg::RANGE_COUNT)) begin
                        cfg_reg.speed_range <= cfg_wr_data[2:0];
                    end
                end
                hjvr_pkg::CFG_RATIO_GAIN: begin
                    cfg_reg.ratio_gain <= cfg_wr_data;
                end
                hjvr_pkg::CFG_MAX_SPEED: begin
                    cfg_reg.max_speed <= cfg_wr_data;
                end
                hjvr_pkg::CFG_MAX_SPEED_STEP: begin
                    cfg_reg.max_speed_step <= cfg_wr_data;
                end
                hjvr_pkg::CFG_TICK_PERIOD: begin
                    cfg_reg.tick_period <= cfg_wr_data[16:0];
                end
                default: begin
                end
            endcase
        end
    end

    hjvr_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_encoder_count  (s_encoder_count),
        .s_load_axis      (s_load_axis),
        .s_start_position (s_start_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position_x     (m_position_x),
        .m_position_y     (m_position_y),
        .m_position_z     (m_position_z),
        .m_velocity_x     (m_velocity_x),
        .m_velocity_y     (m_velocity_y),
        .m_velocity_z     (m_velocity_z),
        .m_count_delta    (m_count_delta)
    );

endmodule

// ===== rtl/hjvr_chk.sv =====
module hjvr_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_position_x,
    input logic signed [63:0] m_position_y,
    input logic signed [63:0] m_position_z,
    input logic signed [31:0] m_velocity_x,
    input logic signed [31:0] m_velocity_y,
    input logic signed [31:0] m_velocity_z,
    input logic signed [15:0] m_count_delta
);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high the cycle after an item was taken");

    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result posted while input side still busy");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear result and free input");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position_x) && $stable(m_position_y)
            && $stable(m_position_z) && $stable(m_velocity_x) && $stable(m_velocity_y)
            && $stable(m_velocity_z) && $stable(m_count_delta))
        else $error("stalled result changed");

endmodule

bind handwheel_jog_velocity_ramp hjvr_chk u_hjvr_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_position_x  (m_position_x),
    .m_position_y  (m_position_y),
    .m_position_z  (m_position_z),
    .m_velocity_x  (m_velocity_x),
    .m_velocity_y  (m_velocity_y),
    .m_velocity_z  (m_velocity_z),
    .m_count_delta (m_count_delta)
);

// ===== test/tb_handwheel_jog_velocity_ramp.sv =====
`timescale 1ns / 1ps

module tb_handwheel_jog_velocity_ramp;

    localparam int LIMIT_CYCLES = 250000;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_PCT     = 18;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 500;
    localparam int QUIET_FROM   = 700;
    localparam int QUIET_TO     = 900;

    localparam longint VEL_MAX = 64'sd2147483647;
    localparam longint VEL_MIN = -64'sd2147483648;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] POS_MIN = 64'h8000_0000_0000_0000;
    localparam longint unsigned RANGE_SPEED [5] = '{1000, 10000, 100000, 1000000, 10000000};

    typedef struct packed {
        logic               op;
        logic [15:0]        cnt;
        logic [1:0]         axis;
        logic signed [63:0] start;
    } jog_cmd_t;

    typedef struct packed {
        logic [2:0][63:0] pos;
        logic [2:0][31:0] vel;
        logic [15:0]      delta;
    } jog_state_t;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               cfg_wr_en        = 1'b0;
    logic [2:0]         cfg_wr_index     = '0;
    logic [23:0]        cfg_wr_data      = '0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic               s_operation      = 1'b0;
    logic [15:0]        s_encoder_count  = '0;
    logic [1:0]         s_load_axis      = '0;
    logic signed [63:0] s_start_position = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic signed [63:0] m_position_x;
    logic signed [63:0] m_position_y;
    logic signed [63:0] m_position_z;
    logic signed [31:0] m_velocity_x;
    logic signed [31:0] m_velocity_y;
    logic signed [31:0] m_velocity_z;
    logic signed [15:0] m_count_delta;

    handwheel_jog_velocity_ramp DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_encoder_count  (s_encoder_count),
        .s_load_axis      (s_load_axis),
        .s_start_position (s_start_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position_x     (m_position_x),
        .m_position_y     (m_position_y),
        .m_position_z     (m_position_z),
        .m_velocity_x     (m_velocity_x),
        .m_velocity_y     (m_velocity_y),
        .m_velocity_z     (m_velocity_z),
        .m_count_delta    (m_count_delta)
    );

    // jog model state and register copies
    logic [2:0]         mdl_mask;
    logic [2:0]         mdl_range;
    logic [23:0]        mdl_gain;
    logic [23:0]        mdl_vmax;
    logic [23:0]        mdl_vstep;
    logic [16:0]        mdl_period;
    logic [15:0]        mdl_prev;
    logic signed [31:0] mdl_vel [3];
    logic signed [63:0] mdl_pos [3];
    longint unsigned    shape_tbl [257];

    jog_cmd_t   pending_cmds [$];
    jog_state_t expected_states [$];
    jog_cmd_t   next_cmd;
    logic [15:0] gen_prev;
    logic       in_taken = 1'b0;
    int         items_in = 0;
    int         results_seen = 0;
    int         errors = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    logic       quiet;
    string      pos_names [3] = '{"position_x", "position_y", "position_z"};
    string      vel_names [3] = '{"velocity_x", "velocity_y", "velocity_z"};

    assign quiet = (items_in >= QUIET_FROM) && (items_in < QUIET_TO);

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [255:0] tenth_power(longint y);
        logic [255:0] acc;
        acc = 256'd1;
        for (int k = 0; k < 10; k++) begin
            acc = acc * 256'(y);
        end
        return acc;
    endfunction

    // floor(65536 * (i/256)^0.7): float estimate, then exact integer correction
    function automatic void build_shape_table();
        logic [255:0] bound;
        real          est;
        longint       y;
        for (int i = 0; i <= 256; i++) begin
            bound = 256'd1;
            for (int k = 0; k < 7; k++) begin
                bound = bound * 256'(i);
            end
            bound = bound << 104;
            est = 65536.0 * ((real'(i) / 256.0) ** 0.7);
            y = $rtoi(est);
            while (tenth_power(y + 1) <= bound) begin
                y++;
            end
            while (y > 0 && tenth_power(y) > bound) begin
                y--;
            end
            shape_tbl[i] = longint'(y);
        end
    endfunction

    function automatic jog_state_t jog_advance(logic op, logic [15:0] cnt, logic [1:0] axis,
                                              logic signed [63:0] start);
        jog_state_t         res;
        logic signed [15:0] d;
        longint             mag;
        longint unsigned    frac;
        longint unsigned    p;
        longint unsigned    k;
        longint unsigned    r;
        longint unsigned    shaped;
        longint unsigned    tgt_mag;
        longint             tgt;
        longint             step;
        longint             dv;
        longint             nv;
        longint             prod;
        logic signed [63:0] sum;
        d = '0;
        if (op == hjvr_pkg::OP_LOAD) begin
            mdl_prev = cnt;
            for (int i = 0; i < 3; i++) begin
                mdl_vel[i] = '0;
            end
            if (axis < 2'd3) begin
                mdl_pos[axis] = start;
            end
        end else if (mdl_mask != 3'd0) begin
            d = cnt - mdl_prev;
            mdl_prev = cnt;
            if (d == 16'sd0) begin
                for (int i = 0; i < 3; i++) begin
                    mdl_vel[i] = 32'((longint'(mdl_vel[i]) * 19) / 20);
                end
            end else begin
                mag = (d < 0) ? -longint'(d) : longint'(d);
                frac = longint'(mag) * longint'(mdl_gain);
                if (frac > 65536) begin
                    frac = 65536;
                end
                p = frac * 256;
                k = p >> 16;
                r = p & 64'hFFFF;
                if (k >= 256) begin
                    shaped = shape_tbl[256];
                end else begin
                    shaped = shape_tbl[k] + (((shape_tbl[k + 1] - shape_tbl[k]) * r) >> 16);
                end
                tgt_mag = (RANGE_SPEED[mdl_range] * shaped + 32768) >> 16;
                if (tgt_mag > longint'(mdl_vmax)) begin
                    tgt_mag = longint'(mdl_vmax);
                end
                tgt = (d < 0) ? -longint'(tgt_mag) : longint'(tgt_mag);
                step = longint'(mdl_vstep);
                for (int i = 0; i < 3; i++) begin
                    if (mdl_mask[i]) begin
                        dv = tgt - longint'(mdl_vel[i]);
                        if (dv > step) begin
                            dv = step;
                        end
                        if (dv < -step) begin
                            dv = -step;
                        end
                        nv = longint'(mdl_vel[i]) + dv;
                        if (nv > VEL_MAX) begin
                            nv = VEL_MAX;
                        end
                        if (nv < VEL_MIN) begin
                            nv = VEL_MIN;
                        end
                        mdl_vel[i] = 32'(nv);
                        prod = nv * longint'(mdl_period);
                        sum = mdl_pos[i] + prod;
                        if (mdl_pos[i][63] == prod[63] && sum[63] != prod[63]) begin
                            sum = prod[63] ? POS_MIN : POS_MAX;
                        end
                        mdl_pos[i] = sum;
                    end
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            res.pos[i] = mdl_pos[i];
            res.vel[i] = mdl_vel[i];
        end
        res.delta = d;
        return res;
    endfunction

    task automatic report(string msg);
        errors++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            report($sformatf("result %0d %s: expected %h, got %h", results_seen, name, want,
                             got));
        end
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        case (idx)
            hjvr_pkg::CFG_AXIS_ENABLE:    mdl_mask = data[2:0];
            hjvr_pkg::CFG_SPEED_RANGE:    if (data[2:0] < hjvr_pkg::RANGE_COUNT) mdl_range = data[2:0];
            hjvr_pkg::CFG_RATIO_GAIN:     mdl_gain = data;
            hjvr_pkg::CFG_MAX_SPEED:      mdl_vmax = data;
            hjvr_pkg::CFG_MAX_SPEED_STEP: mdl_vstep = data;
            hjvr_pkg::CFG_TICK_PERIOD:    mdl_period = data[16:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_cmd(logic op, logic [15:0] cnt, logic [1:0] axis, logic [63:0] start);
        pending_cmds.push_back('{op: op, cnt: cnt, axis: axis, start: start});
        gen_prev = cnt;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || expected_states.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_position();
        logic [63:0] v;
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: v = {32'h7FFF_FFFF, $urandom};
            2: v = {32'h8000_0000, $urandom};
            default: v = 64'($urandom_range(0, 1000000)) - 64'd500000;
        endcase
        return v;
    endfunction

    task automatic push_random_cmd();
        int          sel;
        int          mag;
        logic [15:0] step;
        sel = $urandom_range(0, 99);
        if (sel < 7) begin
            push_cmd(hjvr_pkg::OP_LOAD, 16'($urandom), 2'($urandom_range(0, 3)),
                     pick_position());
        end else if (sel < 15) begin
            push_cmd(hjvr_pkg::OP_TICK, 16'($urandom), 2'($urandom), {$urandom, $urandom});
        end else if (sel < 27) begin
            push_cmd(hjvr_pkg::OP_TICK, gen_prev, 2'($urandom), {$urandom, $urandom});
        end else begin
            mag = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 60);
            step = $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
            push_cmd(hjvr_pkg::OP_TICK, gen_prev + step, 2'($urandom), {$urandom, $urandom});
        end
    endtask

    task automatic random_config();
        if ($urandom_range(0, 9) == 0) begin
            cfg_write(hjvr_pkg::CFG_AXIS_ENABLE, 24'd0);
        end else begin
            cfg_write(hjvr_pkg::CFG_AXIS_ENABLE, 24'($urandom_range(1, 7)));
        end
        cfg_write(hjvr_pkg::CFG_SPEED_RANGE, 24'($urandom_range(0, 7)));
        case ($urandom_range(0, 2))
            0: cfg_write(hjvr_pkg::CFG_RATIO_GAIN, 24'($urandom_range(0, 3000)));
            1: cfg_write(hjvr_pkg::CFG_RATIO_GAIN, 24'($urandom_range(0, 65536)));
            default: cfg_write(hjvr_pkg::CFG_RATIO_GAIN, 24'($urandom));
        endcase
        if ($urandom_range(0, 1)) begin
            cfg_write(hjvr_pkg::CFG_MAX_SPEED, 24'($urandom));
        end else begin
            cfg_write(hjvr_pkg::CFG_MAX_SPEED, 24'($urandom_range(0, 200000)));
        end
        if ($urandom_range(0, 2) != 0) begin
            cfg_write(hjvr_pkg::CFG_MAX_SPEED_STEP, 24'($urandom_range(0, 2000)));
        end else begin
            cfg_write(hjvr_pkg::CFG_MAX_SPEED_STEP, 24'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(hjvr_pkg::CFG_TICK_PERIOD, 24'd1000);
        end else begin
            cfg_write(hjvr_pkg::CFG_TICK_PERIOD, 24'($urandom_range(0, 131071)));
        end
    endtask

    // input channel: offer items from the pending queue
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_cmd = pending_cmds.pop_front();
                s_valid          <= 1'b1;
                s_operation      <= next_cmd.op;
                s_encoder_count  <= next_cmd.cnt;
                s_load_axis      <= next_cmd.axis;
                s_start_position <= next_cmd.start;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_states.push_back(jog_advance(s_operation, s_encoder_count, s_load_axis,
                                                  s_start_position));
            items_in <= items_in + 1;
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // result channel: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!hold_done && items_in >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        jog_state_t got;
        jog_state_t want;
        if (aresetn && m_valid && m_ready) begin
            got.pos   = {m_position_z, m_position_y, m_position_x};
            got.vel   = {m_velocity_z, m_velocity_y, m_velocity_x};
            got.delta = m_count_delta;
            if (expected_states.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want = expected_states.pop_front();
                for (int i = 0; i < 3; i++) begin
                    check_field(pos_names[i], want.pos[i], got.pos[i]);
                    check_field(vel_names[i], 64'(want.vel[i]), 64'(got.vel[i]));
                end
                check_field("count_delta", 64'(want.delta), 64'(got.delta));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        build_shape_table();
        mdl_mask   = 3'd1;
        mdl_range  = hjvr_pkg::RANGE_MID;
        mdl_gain   = 24'd327680;
        mdl_vmax   = 24'd100000;
        mdl_vstep  = 24'd500;
        mdl_period = 17'd1000;
        mdl_prev   = '0;
        gen_prev   = '0;
        for (int i = 0; i < 3; i++) begin
            mdl_vel[i] = '0;
            mdl_pos[i] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults: saturation at the top, wrap extremes, loads incl. a bad axis
        push_cmd(hjvr_pkg::OP_LOAD, 16'h1234, 2'd0, 64'h7FFF_FFFF_FFFF_F000);
        push_cmd(hjvr_pkg::OP_TICK, 16'h1235, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'h1235, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'h9234, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'h1234, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_LOAD, 16'hFFFF, 2'd3, 64'hDEAD_BEEF_0123_4567);
        push_cmd(hjvr_pkg::OP_TICK, 16'h0000, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'hFFFF, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_LOAD, 16'hFFFF, 2'd1, 64'h8000_0000_0000_1000);
        push_cmd(hjvr_pkg::OP_LOAD, 16'hFFFF, 2'd2, 64'h0);
        wait_drained();

        // all axes, coarsest range, every limit wide open
        cfg_write(hjvr_pkg::CFG_AXIS_ENABLE, 24'd7);
        cfg_write(hjvr_pkg::CFG_SPEED_RANGE, 24'(hjvr_pkg::RANGE_MAX));
        cfg_write(hjvr_pkg::CFG_RATIO_GAIN, 24'hFF_FFFF);
        cfg_write(hjvr_pkg::CFG_MAX_SPEED, 24'hFF_FFFF);
        cfg_write(hjvr_pkg::CFG_MAX_SPEED_STEP, 24'hFF_FFFF);
        cfg_write(hjvr_pkg::CFG_TICK_PERIOD, 24'h1_FFFF);
        push_cmd(hjvr_pkg::OP_TICK, 16'hFFFB, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'hFFFB, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'hFFF0, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'h0010, 2'd0, '0);
        wait_drained();

        // invalid range ignored, fine gain, zero period, empty mask, zero gain
        cfg_write(hjvr_pkg::CFG_SPEED_RANGE, 24'd7);
        cfg_write(hjvr_pkg::CFG_RATIO_GAIN, 24'd1);
        cfg_write(hjvr_pkg::CFG_MAX_SPEED_STEP, 24'd300000);
        cfg_write(hjvr_pkg::CFG_TICK_PERIOD, 24'd0);
        push_cmd(hjvr_pkg::OP_TICK, 16'h013C, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'h0010, 2'd0, '0);
        wait_drained();
        cfg_write(hjvr_pkg::CFG_AXIS_ENABLE, 24'd0);
        cfg_write(hjvr_pkg::CFG_SPEED_RANGE, 24'(hjvr_pkg::RANGE_FINEST));
        push_cmd(hjvr_pkg::OP_TICK, 16'h4000, 2'd0, '0);
        wait_drained();
        cfg_write(hjvr_pkg::CFG_AXIS_ENABLE, 24'd6);
        cfg_write(hjvr_pkg::CFG_RATIO_GAIN, 24'd0);
        cfg_write(hjvr_pkg::CFG_MAX_SPEED_STEP, 24'd0);
        cfg_write(hjvr_pkg::CFG_TICK_PERIOD, 24'd1);
        push_cmd(hjvr_pkg::OP_TICK, 16'h4001, 2'd0, '0);
        push_cmd(hjvr_pkg::OP_TICK, 16'h4001, 2'd0, '0);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                cfg_write(hjvr_pkg::CFG_AXIS_ENABLE, 24'd1);
                cfg_write(hjvr_pkg::CFG_SPEED_RANGE, 24'(hjvr_pkg::RANGE_MID));
                cfg_write(hjvr_pkg::CFG_RATIO_GAIN, 24'd327680);
                cfg_write(hjvr_pkg::CFG_MAX_SPEED, 24'd100000);
                cfg_write(hjvr_pkg::CFG_MAX_SPEED_STEP, 24'd500);
                cfg_write(hjvr_pkg::CFG_TICK_PERIOD, 24'd1000);
            end else begin
                random_config();
            end
            repeat (163) push_random_cmd();
            wait_drained();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
